// File: rtl/core/lmrq_pkg.sv
// ----------------------------------------------------------------------------
// Lamport lock manager package
// Shared sizes, codes, state encoding and control structs.
// ----------------------------------------------------------------------------
package lmrq_pkg;

    localparam int NUM_ROADS = 4;
    localparam int NUM_NODES = 16;

    localparam int MODE_W  = 2;
    localparam int ROAD_W  = 2;
    localparam int NODE_W  = 4;
    localparam int STAMP_W = 32;
    localparam int HOLD_W  = 5;
    localparam int ACC_W   = 5;
    localparam int ACC_MAX = 16;

    localparam int SLOT_W  = $clog2(NUM_NODES);
    localparam int SCAN_W  = SLOT_W + 1;
    localparam int ADDR_W  = ROAD_W + SLOT_W;
    localparam int DEPTH   = 2 ** ADDR_W;
    localparam int ENTRY_W = NODE_W + STAMP_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_ACCEPT  = 2'd0,
        MODE_REQUEST = 2'd1,
        MODE_RELEASE = 2'd2,
        MODE_BEGIN   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic prep;
        logic scan;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic in_table_op;
        logic scan_done;
        logic out_free;
    } t_stat;

endpackage

// File: rtl/core/lmrq_if.sv
// ----------------------------------------------------------------------------
// Lamport lock manager channels
// Message input channel and grant result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lmrq_in_if;
    logic                             valid;
    logic                             ready;
    logic [lmrq_pkg::MODE_W-1:0]      mode;
    logic [lmrq_pkg::ROAD_W-1:0]      road;
    logic [lmrq_pkg::NODE_W-1:0]      sender;
    logic [lmrq_pkg::STAMP_W-1:0]     stamp;
    logic signed [lmrq_pkg::HOLD_W-1:0] holder_hint;

    modport source (output valid, mode, road, sender, stamp, holder_hint, input ready);
    modport sink   (input valid, mode, road, sender, stamp, holder_hint, output ready);
endinterface

interface lmrq_out_if;
    logic                               valid;
    logic                               ready;
    logic                               grant_valid;
    logic [lmrq_pkg::NODE_W-1:0]        grant_to;
    logic [lmrq_pkg::ROAD_W-1:0]        grant_road;
    logic [lmrq_pkg::STAMP_W-1:0]       grant_stamp;
    logic signed [lmrq_pkg::HOLD_W-1:0] grant_holder;
    logic [lmrq_pkg::ACC_W-1:0]         accept_total;
    logic [lmrq_pkg::STAMP_W-1:0]       clock_now;

    modport source (output valid, grant_valid, grant_to, grant_road, grant_stamp,
                    grant_holder, accept_total, clock_now, input ready);
    modport sink   (input valid, grant_valid, grant_to, grant_road, grant_stamp,
                    grant_holder, accept_total, clock_now, output ready);
endinterface

// File: rtl/core/lmrq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lmrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/lmrq_ctrl.sv
// ----------------------------------------------------------------------------
// Lamport lock manager controller
// Sequences message capture, slot write, queue scan and result hand-off.
// ----------------------------------------------------------------------------
module lmrq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  lmrq_pkg::t_stat i_stat,
    output lmrq_pkg::t_cmd  o_cmd
);

    lmrq_pkg::t_state r_state;
    lmrq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lmrq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lmrq_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.in_table_op ? lmrq_pkg::ST_PREP : lmrq_pkg::ST_DONE;
                end
            end
            lmrq_pkg::ST_PREP: n_state = lmrq_pkg::ST_SCAN;
            lmrq_pkg::ST_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = lmrq_pkg::ST_DONE;
                end
            end
            lmrq_pkg::ST_DONE: begin
                if (i_stat.out_free) begin
                    n_state = lmrq_pkg::ST_IDLE;
                end
            end
            default: n_state = lmrq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            lmrq_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            lmrq_pkg::ST_PREP: o_cmd.prep = 1'b1;
            lmrq_pkg::ST_SCAN: o_cmd.scan = 1'b1;
            lmrq_pkg::ST_DONE: o_cmd.finish = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// File: rtl/core/lmrq_dp.sv
// ----------------------------------------------------------------------------
// Lamport lock manager datapath
// Holds clock, holders, slot tables and waiting marks; scans for the head.
// ----------------------------------------------------------------------------
module lmrq_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lmrq_pkg::t_cmd                      i_cmd,
    output lmrq_pkg::t_stat                     o_stat,
    input  logic [lmrq_pkg::MODE_W-1:0]         i_mode,
    input  logic [lmrq_pkg::ROAD_W-1:0]         i_road,
    input  logic [lmrq_pkg::NODE_W-1:0]         i_sender,
    input  logic [lmrq_pkg::STAMP_W-1:0]        i_stamp,
    input  logic signed [lmrq_pkg::HOLD_W-1:0]  i_holder_hint,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic                                o_grant_valid,
    output logic [lmrq_pkg::NODE_W-1:0]         o_grant_to,
    output logic [lmrq_pkg::ROAD_W-1:0]         o_grant_road,
    output logic [lmrq_pkg::STAMP_W-1:0]        o_grant_stamp,
    output logic signed [lmrq_pkg::HOLD_W-1:0]  o_grant_holder,
    output logic [lmrq_pkg::ACC_W-1:0]          o_accept_total,
    output logic [lmrq_pkg::STAMP_W-1:0]        o_clock_now
);

    // Captured message.
    logic [lmrq_pkg::MODE_W-1:0]        r_mode;
    logic [lmrq_pkg::ROAD_W-1:0]        r_road;
    logic [lmrq_pkg::NODE_W-1:0]        r_sender;
    logic [lmrq_pkg::STAMP_W-1:0]       r_stamp;
    logic signed [lmrq_pkg::HOLD_W-1:0] r_hint;

    // Architectural state.
    logic [lmrq_pkg::DEPTH-1:0]         r_used;
    logic [lmrq_pkg::DEPTH-1:0]         r_wait;
    logic signed [lmrq_pkg::HOLD_W-1:0] r_holder [lmrq_pkg::NUM_ROADS];
    logic [lmrq_pkg::STAMP_W-1:0]       r_clock;
    logic [lmrq_pkg::ACC_W-1:0]         r_acc;

    // Scan state.
    logic [lmrq_pkg::SCAN_W-1:0]        r_scan_idx;
    logic                               r_rd_pend;
    logic [lmrq_pkg::SLOT_W-1:0]        r_rd_slot;
    logic                               r_best_valid;
    logic [lmrq_pkg::STAMP_W-1:0]       r_best_stamp;
    logic [lmrq_pkg::NODE_W-1:0]        r_best_node;
    logic                               r_match_found;
    logic [lmrq_pkg::SLOT_W-1:0]        r_match_slot;

    // Result register.
    logic                               r_out_valid;
    logic                               r_grant_valid;
    logic [lmrq_pkg::NODE_W-1:0]        r_grant_to;
    logic [lmrq_pkg::ROAD_W-1:0]        r_grant_road;
    logic [lmrq_pkg::STAMP_W-1:0]       r_grant_stamp;
    logic signed [lmrq_pkg::HOLD_W-1:0] r_grant_holder;
    logic [lmrq_pkg::ACC_W-1:0]         r_accept_total;
    logic [lmrq_pkg::STAMP_W-1:0]       r_clock_now;

    logic                               in_road_ok;
    logic                               road_ok;
    logic                               free_found;
    logic [lmrq_pkg::SLOT_W-1:0]        free_slot;
    logic                               scan_issue;
    logic [lmrq_pkg::ENTRY_W-1:0]       rd_entry;
    logic [lmrq_pkg::NODE_W-1:0]        rd_node;
    logic [lmrq_pkg::STAMP_W-1:0]       rd_stamp;
    logic                               rd_used;
    logic                               rd_remove;
    logic                               rd_better;
    logic                               is_msg;
    logic [lmrq_pkg::STAMP_W-1:0]       raised_clock;
    logic signed [lmrq_pkg::HOLD_W-1:0] cur_holder;
    logic signed [lmrq_pkg::HOLD_W-1:0] raised_holder;
    logic                               best_node_ok;
    logic                               grant;
    logic [lmrq_pkg::NODE_W-1:0]        grant_node;
    logic [lmrq_pkg::ACC_W-1:0]         n_acc;

    assign in_road_ok = 32'(i_road) < lmrq_pkg::NUM_ROADS;
    assign road_ok    = 32'(r_road) < lmrq_pkg::NUM_ROADS;

    assign o_stat.in_table_op = in_road_ok &&
        (lmrq_pkg::t_mode'(i_mode) == lmrq_pkg::MODE_REQUEST ||
         lmrq_pkg::t_mode'(i_mode) == lmrq_pkg::MODE_RELEASE);
    assign o_stat.scan_done = (r_scan_idx == lmrq_pkg::SCAN_W'(lmrq_pkg::NUM_NODES)) &&
                              !r_rd_pend;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = lmrq_pkg::NUM_NODES - 1; i >= 0; i--) begin
            if (!r_used[{r_road, lmrq_pkg::SLOT_W'(i)}]) begin
                free_found = 1'b1;
                free_slot  = lmrq_pkg::SLOT_W'(i);
            end
        end
    end

    assign scan_issue = i_cmd.scan &&
                        (r_scan_idx != lmrq_pkg::SCAN_W'(lmrq_pkg::NUM_NODES));

    lmrq_ram #(
        .WIDTH (lmrq_pkg::ENTRY_W),
        .DEPTH (lmrq_pkg::DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.prep && lmrq_pkg::t_mode'(r_mode) == lmrq_pkg::MODE_REQUEST &&
                  free_found),
        .i_waddr ({r_road, free_slot}),
        .i_wdata ({r_sender, r_stamp}),
        .i_re    (scan_issue),
        .i_raddr ({r_road, r_scan_idx[lmrq_pkg::SLOT_W-1:0]}),
        .o_rdata (rd_entry)
    );

    assign rd_node  = rd_entry[lmrq_pkg::ENTRY_W-1:lmrq_pkg::STAMP_W];
    assign rd_stamp = rd_entry[lmrq_pkg::STAMP_W-1:0];
    assign rd_used  = r_used[{r_road, r_rd_slot}];

    // On release, the sender's first entry is left out of the head search.
    assign rd_remove = r_rd_pend && rd_used && !r_match_found && rd_node == r_sender &&
                       lmrq_pkg::t_mode'(r_mode) == lmrq_pkg::MODE_RELEASE;
    assign rd_better = !r_best_valid || rd_stamp < r_best_stamp ||
                       (rd_stamp == r_best_stamp && rd_node < r_best_node);

    assign is_msg        = lmrq_pkg::t_mode'(r_mode) != lmrq_pkg::MODE_BEGIN;
    assign raised_clock  = (is_msg && r_stamp > r_clock) ? r_stamp : r_clock;
    assign cur_holder    = r_holder[r_road];
    assign raised_holder = (is_msg && road_ok && r_hint > cur_holder) ? r_hint : cur_holder;
    assign best_node_ok  = 32'(r_best_node) < lmrq_pkg::NUM_NODES;

    always_comb begin
        grant      = 1'b0;
        grant_node = '0;
        if (road_ok && lmrq_pkg::t_mode'(r_mode) == lmrq_pkg::MODE_REQUEST) begin
            grant      = r_best_valid && r_best_node == r_sender;
            grant_node = r_sender;
        end else if (road_ok && lmrq_pkg::t_mode'(r_mode) == lmrq_pkg::MODE_RELEASE) begin
            grant      = r_best_valid && best_node_ok && r_wait[{r_road, r_best_node}];
            grant_node = r_best_node;
        end
    end

    always_comb begin
        n_acc = r_acc;
        case (lmrq_pkg::t_mode'(r_mode))
            lmrq_pkg::MODE_ACCEPT: begin
                if (32'(r_acc) < lmrq_pkg::ACC_MAX) begin
                    n_acc = r_acc + lmrq_pkg::ACC_W'(1);
                end
            end
            lmrq_pkg::MODE_BEGIN: n_acc = '0;
            default: n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_mode;
            r_road   <= i_road;
            r_sender <= i_sender;
            r_stamp  <= i_stamp;
            r_hint   <= i_holder_hint;
        end
        if (scan_issue) begin
            r_rd_slot <= r_scan_idx[lmrq_pkg::SLOT_W-1:0];
        end
        if (r_rd_pend && rd_used && !rd_remove && rd_better) begin
            r_best_stamp <= rd_stamp;
            r_best_node  <= rd_node;
        end
        if (rd_remove) begin
            r_match_slot <= r_rd_slot;
        end
        if (i_cmd.finish) begin
            r_grant_valid  <= grant;
            r_grant_to     <= grant ? grant_node : '0;
            r_grant_road   <= grant ? r_road : '0;
            r_grant_stamp  <= grant ? raised_clock + lmrq_pkg::STAMP_W'(1) : '0;
            r_grant_holder <= grant ? raised_holder : '0;
            r_accept_total <= n_acc;
            r_clock_now    <= raised_clock + lmrq_pkg::STAMP_W'(grant);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used        <= '0;
            r_wait        <= '0;
            for (int r = 0; r < lmrq_pkg::NUM_ROADS; r++) begin
                r_holder[r] <= '1;
            end
            r_clock       <= '0;
            r_acc         <= '0;
            r_scan_idx    <= '0;
            r_rd_pend     <= 1'b0;
            r_best_valid  <= 1'b0;
            r_match_found <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.prep) begin
                r_scan_idx    <= '0;
                r_rd_pend     <= 1'b0;
                r_best_valid  <= 1'b0;
                r_match_found <= 1'b0;
                if (lmrq_pkg::t_mode'(r_mode) == lmrq_pkg::MODE_REQUEST && free_found) begin
                    r_used[{r_road, free_slot}] <= 1'b1;
                end
            end else begin
                r_rd_pend <= scan_issue;
                if (scan_issue) begin
                    r_scan_idx <= r_scan_idx + lmrq_pkg::SCAN_W'(1);
                end
                if (r_rd_pend && rd_used && !rd_remove && rd_better) begin
                    r_best_valid <= 1'b1;
                end
                if (rd_remove) begin
                    r_match_found <= 1'b1;
                end
            end

            if (i_cmd.finish) begin
                r_clock <= raised_clock + lmrq_pkg::STAMP_W'(grant);
                r_acc   <= n_acc;
                if (road_ok) begin
                    r_holder[r_road] <= raised_holder;
                end
                if (road_ok && lmrq_pkg::t_mode'(r_mode) == lmrq_pkg::MODE_REQUEST) begin
                    if (!grant && 32'(r_sender) < lmrq_pkg::NUM_NODES) begin
                        r_wait[{r_road, r_sender}] <= 1'b1;
                    end
                end
                if (road_ok && lmrq_pkg::t_mode'(r_mode) == lmrq_pkg::MODE_RELEASE) begin
                    if (r_match_found) begin
                        r_used[{r_road, r_match_slot}] <= 1'b0;
                    end
                    if (grant) begin
                        r_wait[{r_road, r_best_node}] <= 1'b0;
                    end
                end
            end

            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_grant_valid  = r_grant_valid;
    assign o_grant_to     = r_grant_to;
    assign o_grant_road   = r_grant_road;
    assign o_grant_stamp  = r_grant_stamp;
    assign o_grant_holder = r_grant_holder;
    assign o_accept_total = r_accept_total;
    assign o_clock_now    = r_clock_now;

endmodule

// File: rtl/core/lamport_mutex_request_queue.sv
// Timing: accept and begin messages go from IDLE straight to DONE, where the result is registered;
// request and release messages pass through PREP and SCAN first, the scan reading the resource's
// sixteen slots through the single read port of the slot memory.
// Throughput: one message at a time; the next beat is taken the cycle after the result is
// registered, later while an earlier result still waits to be taken.
// Reset is synchronous and active low; it clears the clock, counters, slot and waiting marks.
// ----------------------------------------------------------------------------
// Lamport lock manager top level
// Per-resource request queue with Lamport clock and grant generation.
// ----------------------------------------------------------------------------
module lamport_mutex_request_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lmrq_in_if.sink    i_req,
    lmrq_out_if.source o_res
);

    lmrq_pkg::t_cmd  cmd;
    lmrq_pkg::t_stat stat;
    logic            in_ready;

    assign i_req.ready = in_ready;

    lmrq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lmrq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_mode         (i_req.mode),
        .i_road         (i_req.road),
        .i_sender       (i_req.sender),
        .i_stamp        (i_req.stamp),
        .i_holder_hint  (i_req.holder_hint),
        .i_out_ready    (o_res.ready),
        .o_out_valid    (o_res.valid),
        .o_grant_valid  (o_res.grant_valid),
        .o_grant_to     (o_res.grant_to),
        .o_grant_road   (o_res.grant_road),
        .o_grant_stamp  (o_res.grant_stamp),
        .o_grant_holder (o_res.grant_holder),
        .o_accept_total (o_res.accept_total),
        .o_clock_now    (o_res.clock_now)
    );

`ifndef SYNTHESIS
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && in_ready) |=> !in_ready)
        else $error("input taken while a message is in progress");

    a_result_follows_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> o_res.valid)
        else $error("finished message did not produce a result");

    a_grant_stamp_is_clock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.grant_valid) |-> o_res.grant_stamp == o_res.clock_now)
        else $error("grant stamp differs from clock");

    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.grant_valid) |->
        (o_res.grant_to == '0 && o_res.grant_stamp == '0 && o_res.grant_holder == '0))
        else $error("grant fields not cleared without grant");
`endif

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lamport lock manager regression bench
// Drives request, release, accept and begin messages into the lock manager
// with random gaps on both channels. It predicts every result beat from its
// own copy of the per-resource queues, clock and accept count, and compares
// each beat field by field.
// ----------------------------------------------------------------------------
module testbench;

    import lmrq_pkg::*;

    localparam int SETTLE_CYCLES = 30;
    localparam int STALL_LIMIT   = 3000;
    localparam int RANDOM_ITEMS  = 1900;

    typedef struct {
        t_mode                     mode;
        logic [ROAD_W-1:0]         road;
        logic [NODE_W-1:0]         sender;
        logic [STAMP_W-1:0]        stamp;
        logic signed [HOLD_W-1:0]  holder_hint;
    } t_message;

    typedef struct {
        logic                      granted;
        logic [NODE_W-1:0]         to;
        logic [ROAD_W-1:0]         road;
        logic [STAMP_W-1:0]        grant_stamp;
        logic signed [HOLD_W-1:0]  holder;
        logic [ACC_W-1:0]          accepts;
        logic [STAMP_W-1:0]        clock_after;
    } t_grant_result;

    logic i_clk;
    logic i_rst_n;

    lmrq_in_if  req_if ();
    lmrq_out_if res_if ();

    lamport_mutex_request_queue DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // Lock manager state as the bench sees it.
    bit                       slot_busy  [NUM_ROADS][NUM_NODES];
    logic [NODE_W-1:0]        slot_owner [NUM_ROADS][NUM_NODES];
    logic [STAMP_W-1:0]       slot_time  [NUM_ROADS][NUM_NODES];
    bit                       wait_flag  [NUM_ROADS][NUM_NODES];
    logic signed [HOLD_W-1:0] road_holder [NUM_ROADS];
    logic [STAMP_W-1:0]       lamport_clock;
    logic [ACC_W-1:0]         accept_count;

    t_message      messages_to_send [$];
    t_grant_result grants_due [$];

    logic [STAMP_W-1:0] stamp_base;
    int n_planned;
    int n_taken;
    int n_checked;
    int n_errors;
    int n_grants;
    int n_dropped;
    int n_saturated;
    int n_wraps;
    int n_requests;
    int n_releases;
    int send_idle;
    int send_calm;
    int recv_idle;
    int recv_calm;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int queue_head(int r);
        int best;
        best = -1;
        for (int i = 0; i < NUM_NODES; i++) begin
            if (slot_busy[r][i] && (best < 0 || slot_time[r][i] < slot_time[r][best] ||
                (slot_time[r][i] == slot_time[r][best] &&
                 slot_owner[r][i] < slot_owner[r][best])))
                best = i;
        end
        return best;
    endfunction

    function automatic t_grant_result lock_manager_step(t_message m);
        t_grant_result res;
        int head;
        bit done;
        res = '{default: '0};
        done = 1'b0;
        if (m.mode != MODE_BEGIN) begin
            if (m.stamp > lamport_clock)
                lamport_clock = m.stamp;
            if (m.holder_hint > road_holder[m.road])
                road_holder[m.road] = m.holder_hint;
        end
        case (m.mode)
            MODE_ACCEPT: begin
                if (accept_count < ACC_MAX)
                    accept_count = accept_count + 1'b1;
                else
                    n_saturated++;
            end
            MODE_BEGIN: begin
                accept_count = '0;
            end
            MODE_REQUEST: begin
                n_requests++;
                for (int i = 0; i < NUM_NODES; i++) begin
                    if (!done && !slot_busy[m.road][i]) begin
                        slot_busy[m.road][i]  = 1'b1;
                        slot_owner[m.road][i] = m.sender;
                        slot_time[m.road][i]  = m.stamp;
                        done = 1'b1;
                    end
                end
                if (!done)
                    n_dropped++;
                head = queue_head(m.road);
                if (head >= 0 && slot_owner[m.road][head] == m.sender) begin
                    res.granted = 1'b1;
                    res.to      = m.sender;
                end else begin
                    wait_flag[m.road][m.sender] = 1'b1;
                end
            end
            MODE_RELEASE: begin
                n_releases++;
                for (int i = 0; i < NUM_NODES; i++) begin
                    if (!done && slot_busy[m.road][i] && slot_owner[m.road][i] == m.sender) begin
                        slot_busy[m.road][i] = 1'b0;
                        done = 1'b1;
                    end
                end
                head = queue_head(m.road);
                if (head >= 0 && wait_flag[m.road][slot_owner[m.road][head]]) begin
                    wait_flag[m.road][slot_owner[m.road][head]] = 1'b0;
                    res.granted = 1'b1;
                    res.to      = slot_owner[m.road][head];
                end
            end
            default: ;
        endcase
        if (res.granted) begin
            lamport_clock = lamport_clock + 1'b1;
            if (lamport_clock == '0)
                n_wraps++;
            n_grants++;
            res.road        = m.road;
            res.grant_stamp = lamport_clock;
            res.holder      = road_holder[m.road];
        end
        res.accepts     = accept_count;
        res.clock_after = lamport_clock;
        return res;
    endfunction

    function automatic void check_result(t_grant_result want);
        string       tag [7];
        logic [31:0] w [7];
        logic [31:0] g [7];
        tag = '{"grant_valid", "grant_to", "grant_road", "grant_stamp",
                "grant_holder", "accept_total", "clock_now"};
        w = '{32'(want.granted), 32'(want.to), 32'(want.road), want.grant_stamp,
              32'(want.holder), 32'(want.accepts), want.clock_after};
        g = '{32'(res_if.grant_valid), 32'(res_if.grant_to), 32'(res_if.grant_road),
              res_if.grant_stamp, 32'(res_if.grant_holder), 32'(res_if.accept_total),
              res_if.clock_now};
        for (int i = 0; i < 7; i++) begin
            if (w[i] !== g[i]) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h",
                         $time, tag[i], w[i], g[i]);
                n_errors++;
            end
        end
    endfunction

    // A side sometimes runs a stretch of beats back to back.
    function automatic int draw_pause(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
            calm_left = $urandom_range(10, 40);
        return $urandom_range(0, 11);
    endfunction

    function automatic void add_item(t_mode mode, int road, int sender,
                                     logic [STAMP_W-1:0] stamp, int hint);
        t_message m;
        m.mode        = mode;
        m.road        = ROAD_W'(road);
        m.sender      = NODE_W'(sender);
        m.stamp       = stamp;
        m.holder_hint = HOLD_W'(hint);
        messages_to_send.push_back(m);
        n_planned++;
    endfunction

    function automatic logic [STAMP_W-1:0] pick_stamp();
        logic [STAMP_W-1:0] s;
        case ($urandom_range(0, 199))
            0, 1, 2, 3: s = $urandom;
            4:          s = 32'hFFFF_FFFF - $urandom_range(0, 3);
            default:    s = stamp_base + $urandom_range(0, 6);
        endcase
        if (s > stamp_base)
            stamp_base = s;
        return s;
    endfunction

    function automatic int pick_hint();
        return int'($urandom_range(0, 16)) - 1;
    endfunction

    function automatic void add_noise();
        add_item(t_mode'($urandom_range(0, 3)), $urandom_range(0, NUM_ROADS - 1),
                 $urandom_range(0, NUM_NODES - 1), pick_stamp(), pick_hint());
    endfunction

    function automatic void add_lock_round();
        int who [$];
        int road;
        int k;
        int j;
        int tmp;
        road = $urandom_range(0, NUM_ROADS - 1);
        k = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 6);
        for (int i = 0; i < k; i++) begin
            who.push_back($urandom_range(0, NUM_NODES - 1));
            add_item(MODE_REQUEST, road, who[i], pick_stamp(),
                     ($urandom_range(0, 1) == 0) ? who[i] : pick_hint());
            if ($urandom_range(0, 4) == 0)
                add_noise();
        end
        for (int i = k - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = who[i];
            who[i] = who[j];
            who[j] = tmp;
        end
        for (int i = 0; i < k; i++) begin
            if ($urandom_range(0, 11) != 0)
                add_item(MODE_RELEASE, road, who[i], pick_stamp(), pick_hint());
            if ($urandom_range(0, 7) == 0)
                add_item(MODE_RELEASE, road, $urandom_range(0, NUM_NODES - 1),
                         pick_stamp(), pick_hint());
            if ($urandom_range(0, 4) == 0)
                add_item(MODE_ACCEPT, road, $urandom_range(0, NUM_NODES - 1),
                         pick_stamp(), pick_hint());
        end
    endfunction

    // Driver: presents one message per beat after a random number of idle cycles.
    always @(posedge i_clk) begin
        bit sent;
        t_message m;
        sent = req_if.valid && req_if.ready;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (sent) begin
                m.mode        = t_mode'(req_if.mode);
                m.road        = req_if.road;
                m.sender      = req_if.sender;
                m.stamp       = req_if.stamp;
                m.holder_hint = req_if.holder_hint;
                grants_due.push_back(lock_manager_step(m));
                n_taken++;
                send_idle = draw_pause(send_calm);
            end
            if (sent || !req_if.valid) begin
                if (send_idle > 0 || messages_to_send.size() == 0) begin
                    req_if.valid <= 1'b0;
                    if (send_idle > 0)
                        send_idle--;
                end else begin
                    m = messages_to_send.pop_front();
                    req_if.valid       <= 1'b1;
                    req_if.mode        <= m.mode;
                    req_if.road        <= m.road;
                    req_if.sender      <= m.sender;
                    req_if.stamp       <= m.stamp;
                    req_if.holder_hint <= m.holder_hint;
                end
            end
        end
    end

    // Monitor: checks each result beat and stalls the result channel at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (grants_due.size() == 0) begin
                    $display("%0t: stray result beat: expected none, actual clock_now %0h",
                             $time, res_if.clock_now);
                    n_errors++;
                end else begin
                    check_result(grants_due.pop_front());
                end
                n_checked++;
                recv_idle = draw_pause(recv_calm);
            end
            if (recv_idle > 0) begin
                res_if.ready <= 1'b0;
                recv_idle--;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat for %0d cycles, %0d of %0d messages taken",
                 $time, STALL_LIMIT, n_taken, n_planned);
        $display("lamport_mutex_request_queue regression: fail");
        $finish;
    end

    initial begin
        int pick;
        req_if.valid       = 1'b0;
        req_if.mode        = MODE_ACCEPT;
        req_if.road        = '0;
        req_if.sender      = '0;
        req_if.stamp       = '0;
        req_if.holder_hint = '0;
        res_if.ready       = 1'b0;
        i_rst_n            = 1'b0;
        for (int r = 0; r < NUM_ROADS; r++) begin
            for (int i = 0; i < NUM_NODES; i++) begin
                slot_busy[r][i] = 1'b0;
                wait_flag[r][i] = 1'b0;
            end
            road_holder[r] = -1;
        end
        lamport_clock = '0;
        accept_count  = '0;
        stamp_base    = '0;

        // Directed opening: ties, waiting heads, releases without entry, wrap.
        add_item(MODE_ACCEPT,  0, 0,  32'h0,          -1);
        add_item(MODE_ACCEPT,  3, 15, 32'h10,         15);
        add_item(MODE_BEGIN,   2, 9,  32'hFFFF_FFFF,  15);
        add_item(MODE_REQUEST, 1, 15, 32'd32,         15);
        add_item(MODE_REQUEST, 1, 3,  32'd32,         2);
        add_item(MODE_REQUEST, 1, 7,  32'd100,        -1);
        add_item(MODE_REQUEST, 1, 7,  32'd200,        4);
        add_item(MODE_RELEASE, 1, 3,  32'd40,         0);
        add_item(MODE_RELEASE, 1, 15, 32'd41,         0);
        add_item(MODE_RELEASE, 1, 7,  32'd42,         0);
        add_item(MODE_RELEASE, 1, 9,  32'd43,         0);
        add_item(MODE_RELEASE, 1, 7,  32'd44,         0);
        add_item(MODE_RELEASE, 1, 7,  32'd45,         0);
        add_item(MODE_ACCEPT,  3, 0,  32'h0,          -1);
        add_item(MODE_REQUEST, 2, 0,  32'hFFFF_FFFF,  15);
        add_item(MODE_RELEASE, 2, 0,  32'h0,          -1);
        add_item(MODE_REQUEST, 0, 12, 32'h0,          0);
        add_item(MODE_RELEASE, 0, 12, 32'h0,          12);
        add_item(MODE_BEGIN,   0, 0,  32'h0,          0);

        while (n_planned < RANDOM_ITEMS + 19) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                add_lock_round();
            end else if (pick < 70) begin
                repeat ($urandom_range(14, 20))
                    add_item(MODE_ACCEPT, $urandom_range(0, NUM_ROADS - 1),
                             $urandom_range(0, NUM_NODES - 1), pick_stamp(), pick_hint());
                add_item(MODE_BEGIN, $urandom_range(0, NUM_ROADS - 1),
                         $urandom_range(0, NUM_NODES - 1), pick_stamp(), pick_hint());
            end else if (pick < 90) begin
                repeat ($urandom_range(3, 6))
                    add_noise();
            end else begin
                pick = $urandom_range(0, NUM_ROADS - 1);
                for (int n = 0; n < NUM_NODES; n++)
                    add_item(MODE_RELEASE, pick, n, pick_stamp(), pick_hint());
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_taken < n_planned || grants_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (grants_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, grants_due.size());
            n_errors++;
        end
        $display("Covered %0d messages (%0d requests, %0d releases), %0d result beats checked.",
                 n_taken, n_requests, n_releases, n_checked);
        $display("Saw %0d grants, %0d full-table drops, %0d saturated accepts, %0d wraps, %0d mismatches.",
                 n_grants, n_dropped, n_saturated, n_wraps, n_errors);
        if (n_errors == 0) begin
            $display("lamport_mutex_request_queue regression: pass");
        end else begin
            $display("lamport_mutex_request_queue regression: fail");
        end
        $finish;
    end

endmodule
